/* rtl/polyblep_oscillator_sample_top_defines.svh */
// Assertion macros shared by the oscillator checker.
`ifndef POLYBLEP_OSCILLATOR_SAMPLE_TOP_DEFINES_SVH
`define POLYBLEP_OSCILLATOR_SAMPLE_TOP_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define PBO_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Condition that must never hold outside reset.
`define PBO_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

/* rtl/pbo_pkg.sv */
// Shared types, constants and helpers of the band-limited oscillator.
package pbo_pkg;

  localparam int PHASE_BITS_DEF  = 24;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam int DIV_STEPS = 30;
  localparam int LANE_LAT  = DIV_STEPS + 6;
  localparam int SINE_LAT  = 7;

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  localparam logic [30:0] SIN_C1 = 31'd1686629713;
  localparam logic [30:0] SIN_C3 = 31'd693598668;
  localparam logic [30:0] SIN_C5 = 31'd85569306;
  localparam logic [30:0] SIN_C7 = 31'd5026996;
  localparam logic [30:0] SIN_C9 = 31'd172273;

  localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

  typedef enum logic [1:0] {
    WF_SINE   = 2'd0,
    WF_SQUARE = 2'd1,
    WF_SAW    = 2'd2,
    WF_TRI    = 2'd3
  } waveform_e;

  localparam logic [1:0] RGN_NONE   = 2'd0;
  localparam logic [1:0] RGN_AFTER  = 2'd1;
  localparam logic [1:0] RGN_BEFORE = 2'd2;

  typedef struct packed {
    logic signed [33:0] blep;
    logic signed [33:0] blamp;
  } edge_corr_t;

  typedef struct packed {
    waveform_e   wf;
    logic [31:0] p;
  } side_t;

  // (a*b) >> 30 for Q30 operands below 2^31
  function automatic logic [30:0] mul_q30(input logic [30:0] a, input logic [30:0] b);
    logic [61:0] prod;
    prod = {31'd0, a} * {31'd0, b};
    return prod[60:30];
  endfunction

endpackage

/* rtl/polyblep_oscillator_sample_top.sv */
// Top level of the band-limited oscillator sample evaluator.
// A transaction is taken at every clock edge with start_i high; busy_o is
// always low, since the pipeline never stalls. Each accepted transaction
// yields one sample on sample_o with valid_o high for one cycle, after the
// input register, the lane pipeline and the waveform and output registers,
// in order. One item enters per cycle. The edge correction divider resolves
// one quotient bit per stage over 30 stages and is followed by the BLEP and
// BLAMP multiplier chain. The sine path runs alongside and is delayed to match.
module polyblep_oscillator_sample_top #(
  parameter int PHASE_BITS  = pbo_pkg::PHASE_BITS_DEF,
  parameter int SAMPLE_BITS = pbo_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    waveform_i,
  input  logic [PHASE_BITS-1:0]         phase_i,
  input  logic [PHASE_BITS-1:0]         phase_step_i,
  output logic                          valid_o,
  output logic signed [SAMPLE_BITS-1:0] sample_o
);
  import pbo_pkg::*;

  localparam int PSH = 32 - PHASE_BITS;
  localparam int SH  = 32 - SAMPLE_BITS;
  localparam logic signed [34:0] RND = 35'((64'd1 << SH) >> 1);
  localparam logic signed [34:0] HI  = 35'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic signed [34:0] LO  = -HI - 35'sd1;
  localparam logic signed [33:0] Q30 = 34'sd1073741824;

  // Nothing downstream can hold results off.
  assign busy_o = 1'b0;

  // Input register: phases widened to Q0.32.
  logic        s0_vld_q;
  waveform_e   s0_wf_q;
  logic [31:0] s0_p_q, s0_dt_q, s0_ph;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_wf_q <= waveform_e'(waveform_i);
    s0_p_q  <= 32'(phase_i) << PSH;
    s0_dt_q <= 32'(phase_step_i) << PSH;
  end

  // Half-period offset wraps mod 1 for free in 32 bits.
  assign s0_ph = s0_p_q + 32'h8000_0000;

  edge_corr_t corr_p, corr_h;
  logic signed [33:0] sin_y;

  pbo_edge_lane u_lane_p (.clk_i(clk_i), .p_i(s0_p_q), .dt_i(s0_dt_q), .corr_o(corr_p));
  pbo_edge_lane u_lane_h (.clk_i(clk_i), .p_i(s0_ph),  .dt_i(s0_dt_q), .corr_o(corr_h));
  pbo_sine      u_sine   (.clk_i(clk_i), .p_i(s0_p_q), .y_o(sin_y));

  // Side data and valid bits travel alongside the lanes.
  side_t side_q [0:LANE_LAT-1];
  logic  vld_q  [0:LANE_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LANE_LAT; i++) vld_q[i] <= 1'b0;
    end else begin
      vld_q[0] <= s0_vld_q;
      for (int i = 1; i < LANE_LAT; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0].wf <= s0_wf_q;
    side_q[0].p  <= s0_p_q;
    for (int i = 1; i < LANE_LAT; i++) side_q[i] <= side_q[i-1];
  end

  // Waveform assembly in Q30.
  side_t side;
  logic signed [33:0] pv, v_d, v_q;
  logic f_vld_q;

  assign side = side_q[LANE_LAT-1];
  assign pv   = $signed({2'b00, side.p});

  always_comb begin
    unique case (side.wf)
      WF_SINE:   v_d = sin_y;
      WF_SQUARE: v_d = (side.p[31] ? -Q30 : Q30) + corr_p.blep - corr_h.blep;
      WF_SAW:    v_d = $signed({3'b000, side.p[31:1]}) - Q30 - corr_p.blep;
      default:   v_d = (side.p[31] ? (34'sd3 * Q30 - pv) : (pv - Q30))
                       + corr_p.blamp - corr_h.blamp;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      f_vld_q <= vld_q[LANE_LAT-1];
      valid_o <= f_vld_q;
    end
  end

  // Round half up, then saturate.
  logic signed [34:0] vr, r;
  logic signed [SAMPLE_BITS-1:0] sample_d;

  assign vr = {v_q[33], v_q} + RND;
  assign r  = vr >>> SH;

  always_comb begin
    priority if (r > HI) begin
      sample_d = SAMPLE_BITS'(HI);
    end else if (r < LO) begin
      sample_d = SAMPLE_BITS'(LO);
    end else begin
      sample_d = SAMPLE_BITS'(r);
    end
  end

  always_ff @(posedge clk_i) begin
    v_q      <= v_d;
    sample_o <= sample_d;
  end

endmodule

/* rtl/pbo_edge_lane.sv */
// Edge correction lane: region test, pipelined divider, BLEP and BLAMP terms.
module pbo_edge_lane (
  input  logic                clk_i,
  input  logic [31:0]         p_i,
  input  logic [31:0]         dt_i,
  output pbo_pkg::edge_corr_t corr_o
);
  import pbo_pkg::*;

  logic [1:0]           rgn_q [0:DIV_STEPS];
  logic [31:0]          dt_q  [0:DIV_STEPS];
  logic [31:0]          rem_q [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] quo_q [0:DIV_STEPS];

  logic [32:0] sum;
  logic [1:0]  rgn_d;
  logic [31:0] num_d;

  assign sum = {1'b0, p_i} + {1'b0, dt_i};

  always_comb begin
    priority if (dt_i == 32'd0) begin
      rgn_d = RGN_NONE;
      num_d = 32'd0;
    end else if (p_i < dt_i) begin
      rgn_d = RGN_AFTER;
      num_d = p_i;
    end else if (sum[32] && (sum[31:0] != 32'd0)) begin
      rgn_d = RGN_BEFORE;
      num_d = 32'd0 - p_i;
    end else begin
      rgn_d = RGN_NONE;
      num_d = 32'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    rgn_q[0] <= rgn_d;
    dt_q[0]  <= dt_i;
    rem_q[0] <= num_d;
    quo_q[0] <= '0;
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [32:0] shl;
    logic        ge;
    assign shl = {rem_q[k], 1'b0};
    assign ge  = (shl >= {1'b0, dt_q[k]});
    always_ff @(posedge clk_i) begin
      rgn_q[k+1] <= rgn_q[k];
      dt_q[k+1]  <= dt_q[k];
      rem_q[k+1] <= ge ? 32'(shl - {1'b0, dt_q[k]}) : shl[31:0];
      quo_q[k+1] <= {quo_q[k][DIV_STEPS-2:0], ge};
    end
  end

  logic [30:0] a_d;
  logic [30:0] a1_q, sq1_q, sq2_q, sq3_q, sq4_q, a3_q, v3_q, v4_q;
  logic [31:0] dt1_q, dt2_q;
  logic [1:0]  rgn1_q, rgn2_q, rgn3_q, rgn4_q;
  logic [62:0] prod3, prod4, p4_q;
  logic [31:0] blamp_d;
  logic signed [33:0] blep_d;
  edge_corr_t  corr_q;

  assign a_d = Q30_ONE - {1'b0, quo_q[DIV_STEPS]};

  assign prod3 = {31'd0, dt2_q} * {32'd0, a3_q};
  assign prod4 = {32'd0, v3_q} * {31'd0, RECIP3};

  always_ff @(posedge clk_i) begin
    a1_q   <= a_d;
    sq1_q  <= mul_q30(a_d, a_d);
    dt1_q  <= dt_q[DIV_STEPS];
    rgn1_q <= rgn_q[DIV_STEPS];

    a3_q   <= mul_q30(sq1_q, a1_q);
    sq2_q  <= sq1_q;
    dt2_q  <= dt1_q;
    rgn2_q <= rgn1_q;

    v3_q   <= prod3[62:32];
    sq3_q  <= sq2_q;
    rgn3_q <= rgn2_q;

    v4_q   <= v3_q;
    p4_q   <= prod4;
    sq4_q  <= sq3_q;
    rgn4_q <= rgn3_q;

    corr_q.blep  <= blep_d;
    corr_q.blamp <= (rgn4_q == RGN_NONE) ? 34'sd0 : $signed({2'b00, blamp_d});
  end

  // 4v/3 = v + floor(v/3)
  assign blamp_d = {1'b0, v4_q} + {2'b00, p4_q[62:33]};

  always_comb begin
    unique case (rgn4_q)
      RGN_AFTER:  blep_d = -$signed({3'b000, sq4_q});
      RGN_BEFORE: blep_d = $signed({3'b000, sq4_q});
      default:    blep_d = 34'sd0;
    endcase
  end

  assign corr_o = corr_q;

endmodule

/* rtl/pbo_sine.sv */
// Sine from an odd polynomial on a folded quarter wave, aligned to the lanes.
module pbo_sine (
  input  logic               clk_i,
  input  logic [31:0]        p_i,
  output logic signed [33:0] y_o
);
  import pbo_pkg::*;

  localparam int PAD = LANE_LAT - SINE_LAT;

  logic [1:0]  quad_q [1:6];
  logic [30:0] x_q    [1:6];
  logic [30:0] x2_q   [2:5];
  logic [30:0] acc3_q, acc4_q, acc5_q, acc6_q;
  logic [30:0] r_d, y_d;
  logic signed [33:0] y_q [0:PAD];

  assign r_d = {1'b0, p_i[29:0]};
  assign y_d = mul_q30(acc6_q, x_q[6]);

  always_ff @(posedge clk_i) begin
    quad_q[1] <= p_i[31:30];
    x_q[1]    <= p_i[30] ? (Q30_ONE - r_d) : r_d;

    quad_q[2] <= quad_q[1];
    x_q[2]    <= x_q[1];
    x2_q[2]   <= mul_q30(x_q[1], x_q[1]);

    acc3_q <= SIN_C7 - mul_q30(SIN_C9, x2_q[2]);
    acc4_q <= SIN_C5 - mul_q30(acc3_q, x2_q[3]);
    acc5_q <= SIN_C3 - mul_q30(acc4_q, x2_q[4]);
    acc6_q <= SIN_C1 - mul_q30(acc5_q, x2_q[5]);

    for (int i = 3; i <= 6; i++) begin
      quad_q[i] <= quad_q[i-1];
      x_q[i]    <= x_q[i-1];
    end
    for (int i = 3; i <= 5; i++) begin
      x2_q[i] <= x2_q[i-1];
    end

    y_q[0] <= quad_q[6][1] ? -$signed({3'b000, y_d}) : $signed({3'b000, y_d});
    for (int i = 1; i <= PAD; i++) begin
      y_q[i] <= y_q[i-1];
    end
  end

  assign y_o = y_q[PAD];

endmodule

/* rtl/pbo_checker.sv */
// Port-level checks of the oscillator, bound to the top level.
`include "polyblep_oscillator_sample_top_defines.svh"

module pbo_checker #(
  parameter int PHASE_BITS  = pbo_pkg::PHASE_BITS_DEF,
  parameter int SAMPLE_BITS = pbo_pkg::SAMPLE_BITS_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic [1:0]                    waveform_i,
  input logic [PHASE_BITS-1:0]         phase_i,
  input logic [PHASE_BITS-1:0]         phase_step_i,
  input logic                          valid_o,
  input logic signed [SAMPLE_BITS-1:0] sample_o
);
  import pbo_pkg::*;

  localparam int TOTAL_LAT = LANE_LAT + 3;

  logic take;
  logic sine_zero;
  assign take      = start_i && !busy_o;
  assign sine_zero = take && (waveform_i == WF_SINE) && (phase_i == '0);

  `PBO_ASSERT_NEVER(a_never_busy, busy_o)
  `PBO_ASSERT_IMPL(a_result_has_cause, valid_o, $past(take, TOTAL_LAT))
  `PBO_ASSERT_IMPL(a_cause_has_result, take, ##TOTAL_LAT valid_o)
  `PBO_ASSERT_IMPL(a_sine_origin, valid_o && $past(sine_zero, TOTAL_LAT), sample_o == '0)

endmodule

bind polyblep_oscillator_sample_top pbo_checker #(
  .PHASE_BITS(PHASE_BITS),
  .SAMPLE_BITS(SAMPLE_BITS)
) u_pbo_checker (.*);
